// ----- rtl/core/tach_pkg.sv -----
// shared types and constants for the tachometer with bar level
`default_nettype none
package tach_pkg;

    // field widths
    localparam int CMD_W      = 2;
    localparam int RPM_W      = 16;
    localparam int INTERVAL_W = 16;
    localparam int PPR_W      = 4;
    localparam int REDLINE_W  = 16;
    localparam int BW_W       = 6;
    localparam int PULSE_W    = 32;
    localparam int ELAPSED_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PULSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXT   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REDLINE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR      = 2'd3;

    // register reset values
    localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 16'd500;
    localparam logic [PPR_W-1:0]      RESET_PPR      = 4'd4;
    localparam logic [REDLINE_W-1:0]  RESET_REDLINE  = 16'd6500;
    localparam logic [BW_W-1:0]       RESET_BAR      = 6'd8;

    // milliseconds per minute
    localparam logic [15:0] MINUTE_MS = 16'd60000;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [RPM_W-1:0] rpm_value;
    } in_item_t;

    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        logic [BW_W-1:0]  bar_fill;
        logic             new_measurement;
    } out_item_t;

    // request to the speed unit
    typedef struct packed {
        logic                 start;
        logic [PULSE_W-1:0]   pulses;
        logic [ELAPSED_W-1:0] elapsed;
        logic [PPR_W-1:0]     ppr;
    } rpm_req_t;

    // request to the bar unit
    typedef struct packed {
        logic                 start;
        logic [RPM_W-1:0]     rpm;
        logic [BW_W-1:0]      bar_width;
        logic [REDLINE_W-1:0] redline;
    } bar_req_t;

endpackage
`default_nettype wire

// ----- rtl/core/tach_rpm_calc.sv -----
// bit-serial speed unit: pulses*60000 / (elapsed*ppr), saturated to 16 bits
`default_nettype none
module tach_rpm_calc (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tach_pkg::rpm_req_t          req,
    output logic                             done,
    output logic [tach_pkg::RPM_W-1:0]       rpm
);

    localparam int NUM_W = tach_pkg::PULSE_W + 16;
    localparam int DEN_W = tach_pkg::ELAPSED_W + tach_pkg::PPR_W;
    localparam int Q_W   = tach_pkg::RPM_W;
    localparam int CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(Q_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [NUM_W-1:0] mcand_reg, mcand_next;
    logic [15:0]      mult_reg, mult_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] dcand_reg, dcand_next;
    logic [tach_pkg::PPR_W-1:0] dmul_reg, dmul_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    // one restoring division step
    assign trial = {rem_reg, quo_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        num_next   = num_reg;
        dcand_next = dcand_reg;
        dmul_next  = dmul_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next = {16'd0, req.pulses};
                    mult_next  = tach_pkg::MINUTE_MS;
                    num_next   = '0;
                    dcand_next = {{tach_pkg::PPR_W{1'b0}}, req.elapsed};
                    dmul_next  = req.ppr;
                    den_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // shift-add for numerator and denominator together
                if (mult_reg[0])
                begin
                    num_next = num_reg + mcand_reg;
                end
                if (dmul_reg[0])
                begin
                    den_next = den_reg + dcand_reg;
                end
                mcand_next = {mcand_reg[NUM_W-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[15:1]};
                dcand_next = {dcand_reg[DEN_W-2:0], 1'b0};
                dmul_next  = {1'b0, dmul_reg[tach_pkg::PPR_W-1:1]};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                // quotient of 2^16 or more saturates
                if (num_reg[NUM_W-1:Q_W] >= {{(NUM_W-Q_W-DEN_W){1'b0}}, den_reg})
                begin
                    quo_next   = '1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rem_next   = num_reg[Q_W+DEN_W-1:Q_W];
                    quo_next   = num_reg[Q_W-1:0];
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                quo_next = {quo_reg[Q_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        num_reg   <= num_next;
        dcand_reg <= dcand_next;
        dmul_reg  <= dmul_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign done = done_reg;
    assign rpm  = quo_reg;

endmodule
`default_nettype wire

// ----- rtl/core/tach_bar_calc.sv -----
// bit-serial bar unit: rpm*bar_width / redline, clamped to bar_width
`default_nettype none
module tach_bar_calc (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tach_pkg::bar_req_t       req,
    output logic                          done,
    output logic [tach_pkg::BW_W-1:0]     fill
);

    localparam int BW    = tach_pkg::BW_W;
    localparam int RW    = tach_pkg::REDLINE_W;
    localparam int PROD_W = tach_pkg::RPM_W + BW;
    localparam int CNT_W = $clog2(BW);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(BW - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [BW-1:0]     mult_reg, mult_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [BW-1:0]     bw_reg, bw_next;
    logic [RW-1:0]     red_reg, red_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [BW-1:0]     quo_reg, quo_next;
    logic [RW:0]       trial;
    logic              ge;

    // one restoring division step
    assign trial = {rem_reg, quo_reg[BW-1]};
    assign ge    = trial >= {1'b0, red_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        acc_next   = acc_reg;
        bw_next    = bw_reg;
        red_next   = red_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next = {{BW{1'b0}}, req.rpm};
                    mult_next  = req.bar_width;
                    acc_next   = '0;
                    bw_next    = req.bar_width;
                    red_next   = req.redline;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mult_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[PROD_W-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[BW-1:1]};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                // zero redline gives an empty bar, an oversize quotient a full one
                if (red_reg == '0)
                begin
                    quo_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (acc_reg >= {red_reg, {BW{1'b0}}})
                begin
                    quo_next   = '1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rem_next   = acc_reg[PROD_W-1:BW];
                    quo_next   = acc_reg[BW-1:0];
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? RW'(trial - {1'b0, red_reg}) : trial[RW-1:0];
                quo_next = {quo_reg[BW-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        acc_reg   <= acc_next;
        bw_reg    <= bw_next;
        red_reg   <= red_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    // clamp to the bar width
    assign done = done_reg;
    assign fill = (quo_reg > bw_reg) ? bw_reg : quo_reg;

endmodule
`default_nettype wire

// ----- rtl/core/tachometer_with_bar_level.sv -----
// top level of the tachometer with bar level: counters, control and output register
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  tach_pkg::in_item_t  (command, rpm_value)
//  out       output     out_valid/ out_stall tach_pkg::out_item_t (rpm, bar_fill, new_measurement)
//  cfg       input      cfg_we               cfg_index, cfg_data
//
// one item at a time: the result follows the 6-step serial multiply and divide of the bar unit
// (the divide is skipped on a full or empty bar); an item that closes a window first goes through
// the 16-step serial multiply, check and 16-step serial divide of the speed unit, with the divide
// skipped when the speed saturates
// reset clears counters, speed and control and loads the register defaults
// in_stall stays high until the result enters the output register, held while out_stall
`default_nettype none
module tachometer_with_bar_level (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire tach_pkg::in_item_t                 in_item,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output tach_pkg::out_item_t                     out_item,
    input  wire logic                               cfg_we,
    input  wire logic [tach_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tach_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RPM  = 2'd1;
    localparam logic [1:0] ST_BAR  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                           state_reg, state_next;
    logic [tach_pkg::INTERVAL_W-1:0]      interval_reg;
    logic [tach_pkg::PPR_W-1:0]           ppr_reg;
    logic [tach_pkg::REDLINE_W-1:0]       redline_reg;
    logic [tach_pkg::BW_W-1:0]            bw_reg;
    logic [tach_pkg::PULSE_W-1:0]         pulses_reg, pulses_next;
    logic [tach_pkg::ELAPSED_W-1:0]       elapsed_reg, elapsed_next;
    logic [tach_pkg::RPM_W-1:0]           cur_rpm_reg, cur_rpm_next;
    logic                                 fresh_reg, fresh_next;
    logic                                 bar_go_reg, bar_go_next;
    tach_pkg::rpm_req_t                   rpm_req_reg, rpm_req_next;
    logic                                 out_valid_reg, out_valid_next;
    tach_pkg::out_item_t                  out_item_reg, out_item_next;
    logic [tach_pkg::ELAPSED_W-1:0]       el_inc;
    logic                                 accept;
    logic                                 rpm_done;
    logic [tach_pkg::RPM_W-1:0]           rpm_result;
    logic                                 bar_done;
    logic [tach_pkg::BW_W-1:0]            bar_result;
    tach_pkg::bar_req_t                   bar_req;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign el_inc   = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;

    // serial arithmetic units
    tach_rpm_calc u_rpm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rpm_req_reg),
        .done  (rpm_done),
        .rpm   (rpm_result)
    );

    assign bar_req = '{start:     bar_go_reg,
                       rpm:       cur_rpm_reg,
                       bar_width: bw_reg,
                       redline:   redline_reg};

    tach_bar_calc u_bar (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (bar_req),
        .done  (bar_done),
        .fill  (bar_result)
    );

    // sequencing and counters
    always_comb
    begin
        state_next      = state_reg;
        pulses_next     = pulses_reg;
        elapsed_next    = elapsed_reg;
        cur_rpm_next    = cur_rpm_reg;
        fresh_next      = fresh_reg;
        bar_go_next     = 1'b0;
        rpm_req_next    = rpm_req_reg;
        rpm_req_next.start = 1'b0;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fresh_next  = 1'b0;
                    bar_go_next = 1'b1;
                    state_next  = ST_BAR;
                    case (in_item.command)
                        tach_pkg::CMD_TICK:
                        begin
                            if (el_inc >= interval_reg)
                            begin
                                // close the window and hand the counts to the speed unit
                                rpm_req_next.start   = 1'b1;
                                rpm_req_next.pulses  = pulses_reg;
                                rpm_req_next.elapsed = el_inc;
                                rpm_req_next.ppr     = (ppr_reg == '0)
                                                       ? tach_pkg::PPR_W'(1) : ppr_reg;
                                pulses_next  = '0;
                                elapsed_next = '0;
                                fresh_next   = 1'b1;
                                bar_go_next  = 1'b0;
                                state_next   = ST_RPM;
                            end
                            else
                            begin
                                elapsed_next = el_inc;
                            end
                        end
                        tach_pkg::CMD_PULSE:
                        begin
                            if (pulses_reg != '1)
                            begin
                                pulses_next = pulses_reg + 1'b1;
                            end
                        end
                        tach_pkg::CMD_EXT:
                        begin
                            cur_rpm_next = in_item.rpm_value;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RPM:
            begin
                if (rpm_done)
                begin
                    cur_rpm_next = rpm_result;
                    bar_go_next  = 1'b1;
                    state_next   = ST_BAR;
                end
            end
            ST_BAR:
            begin
                if (bar_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // load the result once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                = 1'b1;
                    out_item_next.rpm             = cur_rpm_reg;
                    out_item_next.bar_fill        = bar_result;
                    out_item_next.new_measurement = fresh_reg;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pulses_reg    <= '0;
            elapsed_reg   <= '0;
            cur_rpm_reg   <= '0;
            fresh_reg     <= 1'b0;
            bar_go_reg    <= 1'b0;
            rpm_req_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pulses_reg    <= pulses_next;
            elapsed_reg   <= elapsed_next;
            cur_rpm_reg   <= cur_rpm_next;
            fresh_reg     <= fresh_next;
            bar_go_reg    <= bar_go_next;
            rpm_req_reg   <= rpm_req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= tach_pkg::RESET_INTERVAL;
            ppr_reg      <= tach_pkg::RESET_PPR;
            redline_reg  <= tach_pkg::RESET_REDLINE;
            bw_reg       <= tach_pkg::RESET_BAR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tach_pkg::CFG_INTERVAL: interval_reg <= cfg_data;
                tach_pkg::CFG_PPR:      ppr_reg      <= cfg_data[tach_pkg::PPR_W-1:0];
                tach_pkg::CFG_REDLINE:  redline_reg  <= cfg_data;
                tach_pkg::CFG_BAR:      bw_reg       <= cfg_data[tach_pkg::BW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    // a new result appears only out of the output state
    a_out_from_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("output loaded outside the output state");

    // the speed unit finishes only while it is awaited
    a_rpm_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        rpm_done |-> state_reg == ST_RPM)
        else $error("speed unit finished while not awaited");

    // the bar unit finishes only while it is awaited
    a_bar_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        bar_done |-> state_reg == ST_BAR)
        else $error("bar unit finished while not awaited");

    // a delivered fill never exceeds the bar width
    a_fill_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_item_reg.bar_fill <= bw_reg)
        else $error("bar fill beyond bar width");
`endif

endmodule
`default_nettype wire

// ----- bench/tachometer_with_bar_level_tb.sv -----
// self-checking testbench for the tachometer with bar level
`timescale 1ns / 100ps
`default_nettype none
module tachometer_with_bar_level_tb;

    // command value with no meaning, must be ignored by the block
    localparam logic [tach_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int DRAIN_CYCLES    = 64;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    tach_pkg::in_item_t              in_item = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    tach_pkg::out_item_t             out_item;
    logic                            cfg_we = 1'b0;
    logic [tach_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tach_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // register copies and state of the predicted tachometer
    logic [tach_pkg::INTERVAL_W-1:0] interval_reg;
    logic [tach_pkg::PPR_W-1:0]      ppr_reg;
    logic [tach_pkg::REDLINE_W-1:0]  redline_reg;
    logic [tach_pkg::BW_W-1:0]       bar_width_reg;
    logic [tach_pkg::PULSE_W-1:0]    pulse_count;
    logic [tach_pkg::ELAPSED_W-1:0]  elapsed_count;
    logic [tach_pkg::RPM_W-1:0]      engine_rpm;

    tach_pkg::in_item_t  events_pending[$];
    tach_pkg::out_item_t readings_due[$];
    int                  mismatch_cnt = 0;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;

    tachometer_with_bar_level u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #10 clk = ~clk;

    // predicted reading for one accepted item, updates the predicted state
    function automatic tach_pkg::out_item_t tach_reading(tach_pkg::in_item_t ev);
        tach_pkg::out_item_t        res;
        logic [tach_pkg::PPR_W-1:0] ppr_eff;
        logic [19:0]                span;
        logic [47:0]                scaled;
        logic [21:0]                fill;
        res.new_measurement = 1'b0;
        case (ev.command)
            tach_pkg::CMD_TICK:
            begin
                if (elapsed_count != 16'hFFFF)
                    elapsed_count = elapsed_count + 1'b1;
                if (elapsed_count >= interval_reg)
                begin
                    ppr_eff = (ppr_reg == '0) ? 4'd1 : ppr_reg;
                    span = elapsed_count * ppr_eff;
                    if (span == '0)
                        span = 20'd1;
                    scaled = pulse_count;
                    scaled = scaled * tach_pkg::MINUTE_MS;
                    scaled = scaled / span;
                    engine_rpm = (scaled > 48'hFFFF) ? 16'hFFFF : scaled[15:0];
                    pulse_count = '0;
                    elapsed_count = '0;
                    res.new_measurement = 1'b1;
                end
            end
            tach_pkg::CMD_PULSE:
            begin
                if (pulse_count != 32'hFFFF_FFFF)
                    pulse_count = pulse_count + 1'b1;
            end
            tach_pkg::CMD_EXT:
                engine_rpm = ev.rpm_value;
            default:
                ;
        endcase
        // bar fill scaled to redline, clamped to full width
        if (redline_reg == '0)
            fill = '0;
        else
        begin
            fill = engine_rpm * bar_width_reg;
            fill = fill / redline_reg;
            if (fill > bar_width_reg)
                fill = bar_width_reg;
        end
        res.rpm = engine_rpm;
        res.bar_fill = fill[tach_pkg::BW_W-1:0];
        return res;
    endfunction

    // driver: predicts each accepted item and presents the next pending one
    always @(posedge clk)
    begin : driver
        logic taken;
        if (rst_n)
        begin
            taken = in_valid && !in_stall;
            if (taken)
                readings_due.push_back(tach_reading(in_item));
            if (!in_valid || taken)
            begin
                if (events_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_item <= events_pending.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted reading and drives random stalls
    always @(posedge clk)
    begin : monitor
        tach_pkg::out_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (readings_due.size() == 0)
                begin
                    if (mismatch_cnt < 10)
                        $display("unexpected reading: rpm %0d bar %0d new %0b",
                                 out_item.rpm, out_item.bar_fill, out_item.new_measurement);
                    mismatch_cnt++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (out_item.rpm !== want.rpm || out_item.bar_fill !== want.bar_fill
                        || out_item.new_measurement !== want.new_measurement)
                    begin
                        if (mismatch_cnt < 10)
                        begin
                            $display("reading mismatch at %0t: expected rpm %0d bar %0d new %0b",
                                     $realtime, want.rpm, want.bar_fill, want.new_measurement);
                            $display("    got rpm %0d bar %0d new %0b",
                                     out_item.rpm, out_item.bar_fill, out_item.new_measurement);
                        end
                        mismatch_cnt++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // one register write, mirrored into the predicted registers
    task automatic write_reg(logic [tach_pkg::CFG_IDX_W-1:0] idx,
                             logic [tach_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            tach_pkg::CFG_INTERVAL: interval_reg = data;
            tach_pkg::CFG_PPR:      ppr_reg = data[tach_pkg::PPR_W-1:0];
            tach_pkg::CFG_REDLINE:  redline_reg = data;
            tach_pkg::CFG_BAR:      bar_width_reg = data[tach_pkg::BW_W-1:0];
            default:                ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // all four registers; unused upper data bits carry noise
    task automatic set_regs(int interval, int ppr, int redline, int bar);
        write_reg(tach_pkg::CFG_INTERVAL, 16'(interval));
        write_reg(tach_pkg::CFG_PPR, {12'($urandom), 4'(ppr)});
        write_reg(tach_pkg::CFG_REDLINE, 16'(redline));
        write_reg(tach_pkg::CFG_BAR, {10'($urandom), 6'(bar)});
    endtask

    // wait until nothing is queued, in flight or expected
    task automatic wait_drained();
        @(negedge clk);
        while (events_pending.size() != 0 || in_valid || readings_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_event(logic [tach_pkg::CMD_W-1:0] cmd,
                               logic [tach_pkg::RPM_W-1:0] value);
        tach_pkg::in_item_t ev;
        ev.command = cmd;
        ev.rpm_value = value;
        events_pending.push_back(ev);
    endtask

    // random event mix: mostly ticks and pulses so windows close often
    task automatic queue_random(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 40)
                queue_event(tach_pkg::CMD_TICK, 16'($urandom));
            else if (r < 85)
                queue_event(tach_pkg::CMD_PULSE, 16'($urandom));
            else if (r < 95)
                queue_event(tach_pkg::CMD_EXT, 16'($urandom));
            else
                queue_event(CMD_UNUSED, 16'($urandom));
        end
    endtask

    // stimulus
    initial
    begin
        interval_reg = tach_pkg::RESET_INTERVAL;
        ppr_reg = tach_pkg::RESET_PPR;
        redline_reg = tach_pkg::RESET_REDLINE;
        bar_width_reg = tach_pkg::RESET_BAR;
        pulse_count = '0;
        elapsed_count = '0;
        engine_rpm = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: external speeds, clamp of the bar, ignored command
        queue_event(tach_pkg::CMD_EXT, 16'd0);
        queue_event(tach_pkg::CMD_EXT, 16'hFFFF);
        queue_event(tach_pkg::CMD_EXT, 16'd6500);
        queue_event(tach_pkg::CMD_EXT, 16'd3249);
        queue_event(CMD_UNUSED, 16'hFFFF);
        queue_event(tach_pkg::CMD_PULSE, 16'hFFFF);
        queue_event(tach_pkg::CMD_TICK, 16'h5A5A);
        wait_drained();

        // zero interval closes on every tick, zero pulses per rev, zero redline
        set_regs(0, 0, 0, 63);
        queue_event(tach_pkg::CMD_PULSE, 16'd0);
        queue_event(tach_pkg::CMD_TICK, 16'd0);
        queue_event(tach_pkg::CMD_TICK, 16'hFFFF);
        wait_drained();

        // speed beyond range saturates, fill clamps to width
        set_regs(1, 1, 1, 63);
        queue_event(tach_pkg::CMD_PULSE, 16'd1);
        queue_event(tach_pkg::CMD_PULSE, 16'd2);
        queue_event(tach_pkg::CMD_PULSE, 16'd3);
        queue_event(tach_pkg::CMD_TICK, 16'd4);
        wait_drained();

        // zero bar width, top redline, eight pulses per rev
        set_regs(2, 8, 65535, 0);
        queue_event(tach_pkg::CMD_EXT, 16'hFFFF);
        queue_event(tach_pkg::CMD_PULSE, 16'd0);
        queue_event(tach_pkg::CMD_TICK, 16'd0);
        queue_event(tach_pkg::CMD_TICK, 16'd0);
        queue_event(CMD_UNUSED, 16'd0);
        wait_drained();

        // bar width of 40, largest pulses per rev
        set_regs(65535, 15, 65535, 40);
        queue_event(tach_pkg::CMD_EXT, 16'hFFFF);
        queue_event(tach_pkg::CMD_EXT, 16'h8000);
        queue_event(tach_pkg::CMD_TICK, 16'd0);
        wait_drained();

        // random phases over several settings and idling modes
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_regs((p == 3) ? 65535 : $urandom_range(0, 24),
                     (p == 1) ? 15 : $urandom_range(0, 8),
                     (p == 2) ? 65535 : (p == 5) ? 1 : (p == 6) ? 0 : $urandom_range(1000, 20000),
                     (p == 2) ? 63 : (p == 4) ? 40 : $urandom_range(1, 40));
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            queue_random(ITEMS_PER_PHASE / 2);
            // sender holds off until every reading is back
            wait_drained();
            queue_random(ITEMS_PER_PHASE / 2);
            wait_drained();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && readings_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
